### design/cmr_pkg.sv
// Shared constants and codes for the contact manifold reducer.
package cmr_pkg;

  localparam int MAX_POINTS = 4;
  localparam int NCAND      = MAX_POINTS + 1;
  localparam int IDX_W      = 3;
  localparam int SLOT_W     = 2;
  localparam int CNT_W      = 3;
  localparam int MUL_DIGIT  = 8;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

endpackage

### design/cmr_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
module cmr_front #(
  parameter int DW = 120
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_kind,
  input  logic [DW-1:0] in_data,
  output logic          q_valid,
  input  logic          q_pop,
  output logic          q_clear,
  output logic [DW-1:0] q_data
);

  logic [DW-1:0] data_r [2];
  logic          clear_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_clear   = clear_r[rd_ptr_r];
  assign q_data    = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r]  <= in_data;
      clear_r[wr_ptr_r] <= (in_kind == cmr_pkg::KIND_CLEAR);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("request queue count out of range");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("request queue count did not follow a push");
  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("request queue count did not follow a pop");

endmodule

### design/cmr_mul.sv
// Shared sequential multiplier, one digit of the second operand per cycle.
module cmr_mul #(
  parameter int MW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [MW-1:0]   op_a,
  input  logic [MW-1:0]   op_b,
  output logic            done,
  output logic [2*MW-1:0] prod
);

  localparam int SW    = 2 * MW;
  localparam int DG    = cmr_pkg::MUL_DIGIT;
  localparam int NSTEP = (MW + DG - 1) / DG;
  localparam int CW_S  = $clog2(NSTEP + 1);

  logic [SW-1:0]    a_r;
  logic [MW-1:0]    b_r;
  logic [SW-1:0]    acc_r;
  logic [CW_S-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SW+DG-1:0] pp;

  assign pp   = a_r * b_r[DG-1:0];
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW_S'(NSTEP - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= SW'(op_a);
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_r << DG;
      b_r   <= b_r >> DG;
      acc_r <= acc_r + pp[SW-1:0];
    end
  end

endmodule

### design/cmr_isqrt.sv
// Integer square root, one result bit per cycle (restoring method).
module cmr_isqrt #(
  parameter int SW = 100
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SW-1:0]   radicand,
  output logic            done,
  output logic [SW/2-1:0] root
);

  localparam int RW   = SW / 2;
  localparam int CW_S = $clog2(RW + 1);

  logic [SW-1:0]   rad_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   root_r;
  logic [CW_S-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+2:0]   rem_t;
  logic [RW+2:0]   trial;
  logic            fits;

  assign rem_t = {rem_r, rad_r[SW-1:SW-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = (rem_t >= trial);
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW_S'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (RW+1)'(rem_t - trial) : rem_t[RW:0];
      root_r <= {root_r[RW-2:0], fits};
    end
  end

endmodule

### design/cmr_engine.sv
// Back end: point store, four-point reduction sequencer and result register.
module cmr_engine #(
  parameter int CW = 24,
  parameter int TW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic               q_clear,
  input  logic [4*CW+TW-1:0] q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_slot,
  output logic               out_slot_valid,
  output logic [CW-1:0]      out_x,
  output logic [CW-1:0]      out_y,
  output logic [CW-1:0]      out_z,
  output logic [CW-1:0]      out_depth,
  output logic [TW-1:0]      out_tag,
  output logic [2:0]         out_count,
  output logic               out_last
);

  localparam int MW = 2 * CW + 2;
  localparam int SW = 2 * MW;
  localparam int RW = SW / 2;
  localparam int NC = cmr_pkg::NCAND;
  localparam int IW = cmr_pkg::IDX_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEEP   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_MGO    = 4'd3;
  localparam logic [3:0] S_MWAIT  = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  localparam logic [1:0] P_FAR  = 2'd0;
  localparam logic [1:0] P_TRI  = 2'd1;
  localparam logic [1:0] P_QUAD = 2'd2;

  // Point entries: four live slots through map_r plus one spare entry.
  logic signed [CW-1:0] px_r [NC];
  logic signed [CW-1:0] py_r [NC];
  logic signed [CW-1:0] pz_r [NC];
  logic signed [CW-1:0] pd_r [NC];
  logic [TW-1:0]        pt_r [NC];

  logic [IW-1:0] map_r [cmr_pkg::MAX_POINTS];
  logic [IW-1:0] map_nxt [cmr_pkg::MAX_POINTS];
  logic [IW-1:0] spare_r, spare_nxt;
  logic [2:0]    total_r, total_nxt;
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    pass_r, pass_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] deep_r, deep_nxt, far_r, far_nxt, tri_r, tri_nxt, quad_r, quad_nxt;
  logic          have_r, have_nxt;
  logic [1:0]    k_r, k_nxt, ph_r, ph_nxt;
  logic          half_r, half_nxt;
  logic [1:0]    ek_r, ek_nxt;
  logic          ov_r, ov_nxt;

  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [CW-1:0] tx_r, ty_r, tz_r, cx_r, cy_r, cz_r;
  logic signed [CW-1:0] dbest_r;
  logic [SW-1:0]        acc_r, val_r, best_r;
  logic signed [MW:0]   p0_r;
  logic [RW-1:0]        s1_r;
  logic                 mneg_r;

  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic          we;
  logic [IW-1:0] cm_i;
  logic [IW-1:0] left_idx;
  logic          excl;

  logic signed [CW:0] ux, uy, uz, vx, vy, vz, dx, dy, dz, fa, fb;
  logic signed [CW-1:0] qx, qy, qz;
  logic               use_p0;
  logic [MW:0]        p0abs;
  logic [MW-1:0]      mul_a, mul_b;
  logic               mul_start, mul_done;
  logic [SW-1:0]      mul_prod;
  logic signed [MW:0] sprod;
  logic [SW-1:0]      sum;
  logic               sq_start, sq_done;
  logic [RW-1:0]      sq_root;
  logic               load_out;

  function automatic logic [CW:0] mag1(input logic signed [CW:0] v);
    return v[CW] ? ($unsigned(~v) + {{CW{1'b0}}, 1'b1}) : $unsigned(v);
  endfunction

  function automatic logic [IW-1:0] cmap(input logic [IW-1:0] idx,
                                         input logic [IW-1:0] m0,
                                         input logic [IW-1:0] m1,
                                         input logic [IW-1:0] m2,
                                         input logic [IW-1:0] m3,
                                         input logic [IW-1:0] sp);
    logic [IW-1:0] r;
    unique case (idx)
      3'd0:    r = m0;
      3'd1:    r = m1;
      3'd2:    r = m2;
      3'd3:    r = m3;
      default: r = sp;
    endcase
    return r;
  endfunction

  assign cm_i = cmap(i_r, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
  assign rd_idx = (state_r == S_EMIT) ? map_r[ek_r] : cm_i;

  // The candidate that none of the four picks names becomes the new spare.
  always_comb begin
    left_idx = '0;
    for (int j = 0; j < NC; j++) begin
      if (IW'(j) != deep_r && IW'(j) != far_r && IW'(j) != tri_r && IW'(j) != quad_r) begin
        left_idx = IW'(j);
      end
    end
  end

  always_comb begin
    unique case (pass_r)
      P_FAR:   excl = (i_r == deep_r);
      P_TRI:   excl = (i_r == deep_r) || (i_r == far_r);
      default: excl = (i_r == deep_r) || (i_r == far_r) || (i_r == tri_r);
    endcase
  end

  assign qx = half_r ? tx_r : ax_r;
  assign qy = half_r ? ty_r : ay_r;
  assign qz = half_r ? tz_r : az_r;
  assign ux = (CW+1)'(bx_r) - (CW+1)'(qx);
  assign uy = (CW+1)'(by_r) - (CW+1)'(qy);
  assign uz = (CW+1)'(bz_r) - (CW+1)'(qz);
  assign vx = (CW+1)'(cx_r) - (CW+1)'(qx);
  assign vy = (CW+1)'(cy_r) - (CW+1)'(qy);
  assign vz = (CW+1)'(cz_r) - (CW+1)'(qz);
  assign dx = (CW+1)'(ax_r) - (CW+1)'(cx_r);
  assign dy = (CW+1)'(ay_r) - (CW+1)'(cy_r);
  assign dz = (CW+1)'(az_r) - (CW+1)'(cz_r);

  // Cross product component k is the first product minus the second.
  always_comb begin
    fa     = '0;
    fb     = '0;
    use_p0 = 1'b0;
    if (pass_r == P_FAR) begin
      unique case (ph_r)
        2'd0:    begin fa = dx; fb = dx; end
        2'd1:    begin fa = dy; fb = dy; end
        default: begin fa = dz; fb = dz; end
      endcase
    end else begin
      unique case (ph_r)
        2'd0: begin
          unique case (k_r)
            2'd0:    begin fa = uy; fb = vz; end
            2'd1:    begin fa = uz; fb = vx; end
            default: begin fa = ux; fb = vy; end
          endcase
        end
        2'd1: begin
          unique case (k_r)
            2'd0:    begin fa = uz; fb = vy; end
            2'd1:    begin fa = ux; fb = vz; end
            default: begin fa = uy; fb = vx; end
          endcase
        end
        default: use_p0 = 1'b1;
      endcase
    end
  end

  assign p0abs = p0_r[MW] ? $unsigned(-p0_r) : $unsigned(p0_r);
  assign mul_a = use_p0 ? p0abs[MW-1:0] : MW'(mag1(fa));
  assign mul_b = use_p0 ? p0abs[MW-1:0] : MW'(mag1(fb));
  assign mul_start = (state_r == S_MGO);
  assign sprod = mneg_r ? -$signed({1'b0, mul_prod[MW-1:0]}) : $signed({1'b0, mul_prod[MW-1:0]});
  assign sum   = acc_r + mul_prod;

  cmr_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign sq_start = (state_r == S_MWAIT) && mul_done && (pass_r == P_QUAD)
                    && (ph_r == 2'd2) && (k_r == 2'd2);

  cmr_isqrt #(.SW(SW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign we       = q_pop && !q_clear;
  assign wr_idx   = (total_r == 3'(cmr_pkg::MAX_POINTS)) ? spare_r : map_r[total_r[1:0]];
  assign load_out = (state_r == S_EMIT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    i_nxt     = i_r;
    deep_nxt  = deep_r;
    far_nxt   = far_r;
    tri_nxt   = tri_r;
    quad_nxt  = quad_r;
    have_nxt  = have_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    half_nxt  = half_r;
    ek_nxt    = ek_r;
    total_nxt = total_r;
    spare_nxt = spare_r;
    for (int j = 0; j < cmr_pkg::MAX_POINTS; j++) map_nxt[j] = map_r[j];
    ov_nxt = ov_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        ek_nxt = '0;
        if (q_valid) begin
          if (q_clear) begin
            total_nxt = '0;
            state_nxt = S_EMIT;
          end else if (total_r != 3'(cmr_pkg::MAX_POINTS)) begin
            total_nxt = total_r + 3'd1;
            state_nxt = S_EMIT;
          end else begin
            i_nxt     = '0;
            state_nxt = S_DEEP;
          end
        end
      end
      S_DEEP: begin
        if (i_r == 3'd0 || pd_r[rd_idx] > dbest_r) deep_nxt = i_r;
        if (i_r == 3'(NC - 1)) begin
          pass_nxt  = P_FAR;
          i_nxt     = '0;
          have_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          i_nxt = i_r + 3'd1;
        end
      end
      S_LOAD: begin
        if (i_r == 3'(NC)) begin
          i_nxt    = '0;
          have_nxt = 1'b0;
          unique case (pass_r)
            P_FAR:   pass_nxt = P_TRI;
            P_TRI:   pass_nxt = P_QUAD;
            default: state_nxt = S_COMMIT;
          endcase
        end else if (excl) begin
          i_nxt = i_r + 3'd1;
        end else begin
          k_nxt     = '0;
          ph_nxt    = '0;
          half_nxt  = 1'b0;
          state_nxt = S_MGO;
        end
      end
      S_MGO: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          if (pass_r == P_FAR) begin
            if (ph_r == 2'd2) state_nxt = S_CMP;
            else begin
              ph_nxt    = ph_r + 2'd1;
              state_nxt = S_MGO;
            end
          end else if (ph_r != 2'd2) begin
            ph_nxt    = ph_r + 2'd1;
            state_nxt = S_MGO;
          end else if (k_r != 2'd2) begin
            k_nxt     = k_r + 2'd1;
            ph_nxt    = '0;
            state_nxt = S_MGO;
          end else if (pass_r == P_TRI) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          if (!half_r) begin
            half_nxt  = 1'b1;
            k_nxt     = '0;
            ph_nxt    = '0;
            state_nxt = S_MGO;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (!have_r || val_r > best_r) begin
          unique case (pass_r)
            P_FAR:   far_nxt  = i_r;
            P_TRI:   tri_nxt  = i_r;
            default: quad_nxt = i_r;
          endcase
        end
        have_nxt  = 1'b1;
        i_nxt     = i_r + 3'd1;
        state_nxt = S_LOAD;
      end
      S_COMMIT: begin
        map_nxt[0] = cmap(deep_r, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
        map_nxt[1] = cmap(far_r, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
        map_nxt[2] = cmap(tri_r, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
        map_nxt[3] = cmap(quad_r, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
        spare_nxt  = cmap(left_idx, map_r[0], map_r[1], map_r[2], map_r[3], spare_r);
        total_nxt  = 3'(cmr_pkg::MAX_POINTS);
        ek_nxt     = '0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          ov_nxt = 1'b1;
          if (total_r == 3'd0 || {1'b0, ek_r} + 3'd1 == total_r) state_nxt = S_IDLE;
          else ek_nxt = ek_r + 2'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= P_FAR;
      i_r     <= '0;
      deep_r  <= '0;
      far_r   <= '0;
      tri_r   <= '0;
      quad_r  <= '0;
      have_r  <= 1'b0;
      k_r     <= '0;
      ph_r    <= '0;
      half_r  <= 1'b0;
      ek_r    <= '0;
      total_r <= '0;
      spare_r <= 3'(cmr_pkg::MAX_POINTS);
      for (int j = 0; j < cmr_pkg::MAX_POINTS; j++) map_r[j] <= IW'(j);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      i_r     <= i_nxt;
      deep_r  <= deep_nxt;
      far_r   <= far_nxt;
      tri_r   <= tri_nxt;
      quad_r  <= quad_nxt;
      have_r  <= have_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      half_r  <= half_nxt;
      ek_r    <= ek_nxt;
      total_r <= total_nxt;
      spare_r <= spare_nxt;
      for (int j = 0; j < cmr_pkg::MAX_POINTS; j++) map_r[j] <= map_nxt[j];
      ov_r    <= ov_nxt;
    end
  end

  // Point store, datapath and result registers; the datapath contents only matter while the sequencer uses them.
  always_ff @(posedge clk) begin
    if (we) begin
      px_r[wr_idx] <= $signed(q_data[CW-1:0]);
      py_r[wr_idx] <= $signed(q_data[2*CW-1:CW]);
      pz_r[wr_idx] <= $signed(q_data[3*CW-1:2*CW]);
      pd_r[wr_idx] <= $signed(q_data[4*CW-1:3*CW]);
      pt_r[wr_idx] <= q_data[4*CW+TW-1:4*CW];
    end
    if (state_r == S_DEEP && (i_r == 3'd0 || pd_r[rd_idx] > dbest_r)) begin
      dbest_r <= pd_r[rd_idx];
      ax_r    <= px_r[rd_idx];
      ay_r    <= py_r[rd_idx];
      az_r    <= pz_r[rd_idx];
    end
    if (state_r == S_LOAD) begin
      cx_r  <= px_r[rd_idx];
      cy_r  <= py_r[rd_idx];
      cz_r  <= pz_r[rd_idx];
      acc_r <= '0;
    end
    if (state_r == S_MGO) mneg_r <= fa[CW] ^ fb[CW];
    if (state_r == S_MWAIT && mul_done) begin
      if (pass_r == P_FAR) begin
        acc_r <= sum;
        val_r <= sum;
      end else begin
        unique case (ph_r)
          2'd0:    p0_r <= sprod;
          2'd1:    p0_r <= p0_r - sprod;
          default: begin
            acc_r <= sum;
            val_r <= sum;
          end
        endcase
      end
    end
    if (state_r == S_SQRT && sq_done) begin
      if (!half_r) begin
        s1_r  <= sq_root;
        acc_r <= '0;
      end else begin
        val_r <= SW'(s1_r) + SW'(sq_root);
      end
    end
    if (state_r == S_CMP && (!have_r || val_r > best_r)) begin
      best_r <= val_r;
      if (pass_r == P_FAR) begin
        bx_r <= cx_r;
        by_r <= cy_r;
        bz_r <= cz_r;
      end else if (pass_r == P_TRI) begin
        tx_r <= cx_r;
        ty_r <= cy_r;
        tz_r <= cz_r;
      end
    end
    if (load_out) begin
      out_slot       <= ek_r;
      out_slot_valid <= (total_r != 3'd0);
      out_x          <= (total_r != 3'd0) ? px_r[rd_idx] : '0;
      out_y          <= (total_r != 3'd0) ? py_r[rd_idx] : '0;
      out_z          <= (total_r != 3'd0) ? pz_r[rd_idx] : '0;
      out_depth      <= (total_r != 3'd0) ? pd_r[rd_idx] : '0;
      out_tag        <= (total_r != 3'd0) ? pt_r[rd_idx] : '0;
      out_count      <= total_r;
      out_last       <= (total_r == 3'd0) || ({1'b0, ek_r} + 3'd1 == total_r);
    end
  end

  assign out_valid = ov_r;

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 3'(cmr_pkg::MAX_POINTS))
    else $error("stored point count above capacity");
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MWAIT)
    else $error("multiplier finished while the sequencer was not waiting");
  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_SQRT)
    else $error("square root finished while the sequencer was not waiting");
  a_commit_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |=> total_r == 3'(cmr_pkg::MAX_POINTS) && state_r == S_EMIT)
    else $error("reduction did not leave a full store");

endmodule

### design/contact_manifold_reducer_core.sv
// Top level of the contact manifold reducer: stream ports, front queue and back end.
//
// Input stream (in_*): one request per accepted beat. in_tuser is the kind
// (0 adds the point in in_tdata, 1 clears the store). Output stream (out_*):
// after each request the stored points are reported slot by slot, out_tlast
// on the final one; an empty store gives one beat with out_tuser low.
// Adding to a store with room, or clearing, makes the first result beat valid
// once the request has passed the queue, the back end's emit state and the
// result register, one beat per cycle after that while out_tready is high.
// Adding to a full store runs the four-point reduction: a depth scan over the
// five candidates, then distance, triangle and area-sum passes that share one
// multiplier (8 bits per cycle) and a square root unit (one bit per cycle).
// The multiplier and square root units set how long a request takes.
// A two-entry request queue keeps accepting while the back end works, and a
// result register holds a beat while out_tready is low; the back end then
// waits, and the queue fills and drops in_tready.
// Reset (rst_n low, synchronous) empties the store, the request queue and the result register.
module contact_manifold_reducer_core #(
  parameter int COORD_WIDTH = 24,
  parameter int TAG_WIDTH   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // pos_x, pos_y, pos_z, depth, contact_tag from bit 0 up, zero padded
  input  logic [((4*COORD_WIDTH+TAG_WIDTH+7)/8)*8-1:0] in_tdata,
  // kind
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // slot, out_x, out_y, out_z, out_depth, out_tag, stored_count from bit 0 up
  output logic [((4*COORD_WIDTH+TAG_WIDTH+cmr_pkg::SLOT_W+cmr_pkg::CNT_W+7)/8)*8-1:0] out_tdata,
  // slot_valid
  output logic               out_tuser,
  output logic               out_tlast
);

  localparam int CW     = COORD_WIDTH;
  localparam int TW     = TAG_WIDTH;
  localparam int PW     = 4 * CW + TW;
  localparam int OUT_DW = ((PW + cmr_pkg::SLOT_W + cmr_pkg::CNT_W + 7) / 8) * 8;

  logic          q_valid;
  logic          q_pop;
  logic          q_clear;
  logic [PW-1:0] q_data;
  logic [1:0]    r_slot;
  logic [CW-1:0] r_x, r_y, r_z, r_d;
  logic [TW-1:0] r_tag;
  logic [2:0]    r_count;

  cmr_front #(.DW(PW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_data   (in_tdata[PW-1:0]),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_clear   (q_clear),
    .q_data    (q_data)
  );

  cmr_engine #(.CW(CW), .TW(TW)) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_clear        (q_clear),
    .q_data         (q_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_slot       (r_slot),
    .out_slot_valid (out_tuser),
    .out_x          (r_x),
    .out_y          (r_y),
    .out_z          (r_z),
    .out_depth      (r_d),
    .out_tag        (r_tag),
    .out_count      (r_count),
    .out_last       (out_tlast)
  );

  assign out_tdata = OUT_DW'({r_count, r_tag, r_d, r_z, r_y, r_x, r_slot});

endmodule
